>>> src/mi4_pkg.sv
// Shared types, constants, tables and arithmetic helpers of the 4x4 matrix inverter.
`default_nettype none
package mi4_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ACC_W          = 64;
  localparam int THR_W          = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int MINORS         = 12;
  localparam int MIN_AW         = $clog2(MINORS);

  localparam logic [ACC_W-1:0] LIM64 = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] PH_MIN = 2'd0;
  localparam logic [1:0] PH_DET = 2'd1;
  localparam logic [1:0] PH_ADJ = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
  } q_ctrl_t;

  typedef struct packed {
    logic       a_min;
    logic [3:0] a_idx;
    logic       b_min;
    logic [3:0] b_idx;
    logic       neg;
    logic       first;
    logic       last;
  } step_t;

  // cofactor terms: element indices, minor indices (a0..a5 = 0..5, b0..b5 = 6..11), sign
  localparam logic [3:0] COF_E [16][3] = '{
    '{4'd5, 4'd9, 4'd13}, '{4'd1, 4'd9, 4'd13}, '{4'd1, 4'd5, 4'd13}, '{4'd1, 4'd5, 4'd9},
    '{4'd4, 4'd8, 4'd12}, '{4'd0, 4'd8, 4'd12}, '{4'd0, 4'd4, 4'd12}, '{4'd0, 4'd4, 4'd8},
    '{4'd7, 4'd11, 4'd15}, '{4'd3, 4'd11, 4'd15}, '{4'd3, 4'd7, 4'd15}, '{4'd3, 4'd7, 4'd11},
    '{4'd6, 4'd10, 4'd14}, '{4'd2, 4'd10, 4'd14}, '{4'd2, 4'd6, 4'd14}, '{4'd2, 4'd6, 4'd10}
  };
  localparam logic [3:0] COF_M [16][3] = '{
    '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd8, 4'd7}, '{4'd10, 4'd8, 4'd6}, '{4'd9, 4'd7, 4'd6},
    '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd8, 4'd7}, '{4'd10, 4'd8, 4'd6}, '{4'd9, 4'd7, 4'd6},
    '{4'd5, 4'd4, 4'd3}, '{4'd5, 4'd2, 4'd1}, '{4'd4, 4'd2, 4'd0}, '{4'd3, 4'd1, 4'd0},
    '{4'd5, 4'd4, 4'd3}, '{4'd5, 4'd2, 4'd1}, '{4'd4, 4'd2, 4'd0}, '{4'd3, 4'd1, 4'd0}
  };
  localparam logic [15:0] COF_NEG = 16'b0101_1010_0101_1010;

  localparam logic [1:0] PAIR_P [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_Q [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  function automatic logic [ACC_W-1:0] mag64(input logic [ACC_W-1:0] v);
    return v[ACC_W-1] ? (~v + 64'd1) : v;
  endfunction

  // add with symmetric saturation to +-(2^63-1)
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = $signed({a[ACC_W-1], a}) + $signed({b[ACC_W-1], b});
    if (s > $signed({1'b0, LIM64})) return LIM64;
    if (s < -$signed({1'b0, LIM64})) return ~LIM64 + 64'd1;
    return s[ACC_W-1:0];
  endfunction

  function automatic step_t step_info(input logic [1:0] ph, input logic [3:0] j,
                                      input logic [1:0] t);
    step_t      s;
    logic [3:0] jk;
    logic [2:0] k;
    logic       hi;
    s  = '0;
    hi = (j >= 4'd6);
    jk = hi ? (j - 4'd6) : j;
    k  = jk[2:0];
    case (ph)
      PH_MIN: begin
        if (t == 2'd0) begin
          s.a_idx = {PAIR_P[k], hi, 1'b0};
          s.b_idx = {PAIR_Q[k], hi, 1'b1};
        end else begin
          s.a_idx = {PAIR_Q[k], hi, 1'b0};
          s.b_idx = {PAIR_P[k], hi, 1'b1};
          s.neg   = 1'b1;
        end
        s.first = (t == 2'd0);
        s.last  = (t == 2'd1);
      end
      PH_DET: begin
        s.a_min = 1'b1;
        s.b_min = 1'b1;
        s.a_idx = j;
        s.b_idx = 4'd11 - j;
        s.neg   = (j == 4'd1) || (j == 4'd4);
        s.first = (j == 4'd0);
        s.last  = (j == 4'd5);
      end
      PH_ADJ: begin
        s.b_min = 1'b1;
        s.a_idx = COF_E[j][t];
        s.b_idx = COF_M[j][t];
        s.neg   = COF_NEG[j] ^ (t == 2'd1);
        s.first = (t == 2'd0);
        s.last  = (t == 2'd2);
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> src/matrix4_inverse.sv
// Top level of the 4x4 fixed-point matrix inverter.
// Rows enter one per cycle, while elem_stall is low, into a four-row queue; once the fourth
// row of a matrix is in, the engine works out the twelve 2x2 minors, the determinant
// and the sixteen cofactors with one shared multiplier (78 products, four 32x32 partial
// products each) and divides every cofactor by the determinant in a bit-serial divider;
// the divider dominates the run time of a regular matrix. Results leave through an
// output register: four rows with last_row on the fourth, or one zero row flagged
// singular when the determinant magnitude is at or below the configured threshold
// (raw Q units, reset 1). The next matrix's rows may be queued while one is being inverted.
`default_nettype none
module matrix4_inverse
  import mi4_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire         [THR_W-1:0]      cfg_data,
  input  wire                          elem_valid,
  output logic                         elem_stall,
  input  wire  signed [DATA_WIDTH-1:0] elem_col0,
  input  wire  signed [DATA_WIDTH-1:0] elem_col1,
  input  wire  signed [DATA_WIDTH-1:0] elem_col2,
  input  wire  signed [DATA_WIDTH-1:0] elem_col3,
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic signed [DATA_WIDTH-1:0] out_col0,
  output logic signed [DATA_WIDTH-1:0] out_col1,
  output logic signed [DATA_WIDTH-1:0] out_col2,
  output logic signed [DATA_WIDTH-1:0] out_col3,
  output logic                         singular,
  output logic                         last_row
);

  logic [THR_W-1:0]        threshold;
  q_ctrl_t                 head;
  logic [4*DATA_WIDTH-1:0] head_data;
  logic                    pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  mi4_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst(rst), .elem_valid(elem_valid), .elem_stall(elem_stall),
    .row_in({elem_col3, elem_col2, elem_col1, elem_col0}),
    .head(head), .head_data(head_data), .pop(pop)
  );

  mi4_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .head(head), .head_data(head_data), .pop(pop),
    .threshold(threshold), .result_valid(result_valid), .result_stall(result_stall),
    .out_col0(out_col0), .out_col1(out_col1), .out_col2(out_col2), .out_col3(out_col3),
    .singular(singular), .last_row(last_row)
  );

`ifndef SYNTHESIS
  // a singular transfer is a single zero row that closes the matrix
  a_singular_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && singular) |-> (last_row && out_col0 == '0 && out_col1 == '0 &&
                                    out_col2 == '0 && out_col3 == '0))
    else $error("singular result not a closing zero row");

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");

  // the queue only drains into the engine when it holds a row
  a_pop_head: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("row taken from empty queue");
`endif

endmodule
`default_nettype wire

>>> src/mi4_front.sv
// Front end: accepts rows, tags each with its row number and queues them for the engine.
`default_nettype none
module mi4_front
  import mi4_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      elem_valid,
  output logic                     elem_stall,
  input  wire  [4*DATA_WIDTH-1:0]  row_in,
  output q_ctrl_t                  head,
  output logic [4*DATA_WIDTH-1:0]  head_data,
  input  wire                      pop
);

  logic [4*DATA_WIDTH-1:0] qdata [QUEUE_DEPTH];
  logic [1:0]              qrow  [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wptr, rptr;
  logic [QPTR_W:0]         count;
  logic [1:0]              row_count;
  logic                    push, take;

  assign elem_stall = (count == QUEUE_DEPTH[QPTR_W:0]);
  assign push       = elem_valid && !elem_stall;
  assign take       = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.row   = qrow[rptr];
  assign head_data  = qdata[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qdata[wptr] <= row_in;
      qrow[wptr]  <= row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      count     <= '0;
      row_count <= '0;
    end else begin
      if (push) begin
        wptr      <= wptr + QPTR_W'(1);
        row_count <= row_count + 2'd1;
      end
      if (take) rptr <= rptr + QPTR_W'(1);
      count <= count + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, take};
    end
  end

endmodule
`default_nettype wire

>>> src/mi4_mul.sv
// Shared Q-format multiplier: 64x64 magnitude product from four 32x32 partial products.
`default_nettype none
module mi4_mul
  import mi4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire  [ACC_W-1:0] a,
  input  wire  [ACC_W-1:0] b,
  output logic             done,
  output logic [ACC_W-1:0] p
);

  logic [ACC_W-1:0]   ma, mb;
  logic               neg, busy;
  logic [2:0]         cnt;
  logic [2*ACC_W-1:0] prod, addend;
  logic [31:0]        ha, hb;
  logic [63:0]        pp;
  logic               over;
  logic [ACC_W-1:0]   m;

  assign ha   = cnt[1] ? ma[63:32] : ma[31:0];
  assign hb   = cnt[0] ? mb[63:32] : mb[31:0];
  assign pp   = ha * hb;
  assign over = |prod[2*ACC_W-1:FRAC_BITS+63];
  assign m    = over ? LIM64 : {1'b0, prod[FRAC_BITS+62:FRAC_BITS]};

  always_comb begin
    case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    addend = {64'd0, pp};
      2'd1:    addend = {32'd0, pp, 32'd0};
      default: addend = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= mag64(a);
      mb   <= mag64(b);
      neg  <= a[ACC_W-1] ^ b[ACC_W-1];
      prod <= '0;
    end else if (busy && !cnt[2]) begin
      prod <= prod + addend;
    end else if (busy) begin
      p <= neg ? (~m + 64'd1) : m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt[2]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/mi4_div.sv
// Restoring divider: (num << FRAC_BITS) / den, one quotient bit per cycle, saturated.
`default_nettype none
module mi4_div
  import mi4_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire  [ACC_W-1:0]      num,
  input  wire  [ACC_W-1:0]      den,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quot
);

  localparam logic [ACC_W-1:0] POS_MAX = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
  localparam logic [ACC_W-1:0] NEG_MAX = 64'd1 << (DATA_WIDTH - 1);

  logic [2*ACC_W-1:0] dvd;
  logic [ACC_W-1:0]   md, rem, q, maxm, qs;
  logic [ACC_W:0]     r2, r2d;
  logic               neg, over, busy, fits;
  logic [7:0]         cnt;

  assign r2   = {rem, dvd[2*ACC_W-1]};
  assign r2d  = r2 - {1'b0, md};
  assign fits = (r2 >= {1'b0, md});
  assign maxm = neg ? NEG_MAX : POS_MAX;
  assign qs   = (over || (q > maxm)) ? maxm : q;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {64'd0, mag64(num)} << FRAC_BITS;
      md   <= mag64(den);
      neg  <= num[ACC_W-1] ^ den[ACC_W-1];
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
    end else if (busy && !cnt[7]) begin
      dvd <= dvd << 1;
      rem <= fits ? r2d[ACC_W-1:0] : r2[ACC_W-1:0];
      // upper half of the dividend only signals overflow
      if (!cnt[6]) begin
        if (fits) over <= 1'b1;
      end else begin
        q <= {q[ACC_W-2:0], fits};
      end
    end else if (busy) begin
      quot <= neg ? (~qs[DATA_WIDTH-1:0] + DATA_WIDTH'(1)) : qs[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt[7]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 8'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/mi4_back.sv
// Back end: stores the matrix, sequences minors, determinant, cofactors and divisions, drives results.
`default_nettype none
module mi4_back
  import mi4_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  q_ctrl_t                      head,
  input  wire         [4*DATA_WIDTH-1:0] head_data,
  output logic                         pop,
  input  wire         [THR_W-1:0]      threshold,
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic signed [DATA_WIDTH-1:0] out_col0,
  output logic signed [DATA_WIDTH-1:0] out_col1,
  output logic signed [DATA_WIDTH-1:0] out_col2,
  output logic signed [DATA_WIDTH-1:0] out_col3,
  output logic                         singular,
  output logic                         last_row
);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_FA   = 4'd1;
  localparam logic [3:0] ST_FB   = 4'd2;
  localparam logic [3:0] ST_FC   = 4'd3;
  localparam logic [3:0] ST_MW   = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_SING = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state;
  logic [1:0] phase, t;
  logic [3:0] j;
  step_t      info;

  logic [4*DATA_WIDTH-1:0] row_mem [4];
  logic [4*DATA_WIDTH-1:0] rd_row;
  logic [ACC_W-1:0]        min_mem [MINORS];
  logic [ACC_W-1:0]        rd_min;
  logic [1:0]              st_raddr;
  logic [MIN_AW-1:0]       mn_raddr;
  logic                    sel_min;
  logic [1:0]              sel_col;
  logic [DATA_WIDTH-1:0]   elem;
  logic [ACC_W-1:0]        opval, op_a, acc, det, sum, term;
  logic                    mul_start, mul_done, div_start, div_done;
  logic [ACC_W-1:0]        mul_p;
  logic [DATA_WIDTH-1:0]   div_q;
  logic [DATA_WIDTH-1:0]   rowbuf [4];
  logic                    out_free, min_we, load_out;

  assign info     = step_info(phase, j, t);
  assign out_free = !result_valid || !result_stall;
  assign load_out = ((state == ST_SING) || (state == ST_OUT)) && out_free;
  assign pop      = (state == ST_LOAD) && head.valid;

  assign st_raddr = (state == ST_FB) ? info.b_idx[3:2] : info.a_idx[3:2];
  assign mn_raddr = (state == ST_FB) ? info.b_idx[MIN_AW-1:0] : info.a_idx[MIN_AW-1:0];
  assign elem     = rd_row[sel_col*DATA_WIDTH +: DATA_WIDTH];
  assign opval    = sel_min ? rd_min : {{(ACC_W-DATA_WIDTH){elem[DATA_WIDTH-1]}}, elem};

  assign term      = info.neg ? (~mul_p + 64'd1) : mul_p;
  assign sum       = sat_add(info.first ? '0 : acc, term);
  assign mul_start = (state == ST_FC);
  assign div_start = (state == ST_MW) && mul_done && info.last && (phase == PH_ADJ);
  assign min_we    = (state == ST_MW) && mul_done && info.last && (phase == PH_MIN);

  always_ff @(posedge clk) begin
    if (pop) row_mem[head.row] <= head_data;
    rd_row <= row_mem[st_raddr];
    if (min_we) min_mem[j[MIN_AW-1:0]] <= sum;
    rd_min <= min_mem[mn_raddr];
  end

  mi4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(op_a), .b(opval),
    .done(mul_done), .p(mul_p)
  );

  mi4_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum), .den(det),
    .done(div_done), .quot(div_q)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_FA || state == ST_FB) begin
      sel_min <= (state == ST_FB) ? info.b_min : info.a_min;
      sel_col <= (state == ST_FB) ? info.b_idx[1:0] : info.a_idx[1:0];
    end
    if (state == ST_FB) op_a <= opval;
    if (state == ST_MW && mul_done) begin
      acc <= sum;
      if (phase == PH_DET && info.last) det <= sum;
    end
    if (state == ST_DIV && div_done) rowbuf[j[1:0]] <= div_q;
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_SING && out_free) begin
      out_col0 <= '0;
      out_col1 <= '0;
      out_col2 <= '0;
      out_col3 <= '0;
      singular <= 1'b1;
      last_row <= 1'b1;
    end else if (state == ST_OUT && out_free) begin
      out_col0 <= rowbuf[0];
      out_col1 <= rowbuf[1];
      out_col2 <= rowbuf[2];
      out_col3 <= rowbuf[3];
      singular <= 1'b0;
      last_row <= (j == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      phase        <= PH_MIN;
      j            <= '0;
      t            <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (head.valid && head.row == 2'd3) begin
            phase <= PH_MIN;
            j     <= '0;
            t     <= '0;
            state <= ST_FA;
          end
        end
        ST_FA: state <= ST_FB;
        ST_FB: state <= ST_FC;
        ST_FC: state <= ST_MW;
        ST_MW: begin
          if (mul_done) begin
            case (phase)
              PH_MIN: begin
                if (t == 2'd1) begin
                  t <= '0;
                  if (j == 4'd11) begin
                    phase <= PH_DET;
                    j     <= '0;
                  end else begin
                    j <= j + 4'd1;
                  end
                end else begin
                  t <= t + 2'd1;
                end
                state <= ST_FA;
              end
              PH_DET: begin
                if (j == 4'd5) begin
                  state <= ST_CHK;
                end else begin
                  j     <= j + 4'd1;
                  state <= ST_FA;
                end
              end
              default: begin
                if (t == 2'd2) begin
                  state <= ST_DIV;
                end else begin
                  t     <= t + 2'd1;
                  state <= ST_FA;
                end
              end
            endcase
          end
        end
        ST_CHK: begin
          if (mag64(det) <= {{(ACC_W-THR_W){1'b0}}, threshold}) begin
            state <= ST_SING;
          end else begin
            phase <= PH_ADJ;
            j     <= '0;
            t     <= '0;
            state <= ST_FA;
          end
        end
        ST_SING: begin
          if (out_free) begin
            state <= ST_LOAD;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (j[1:0] == 2'd3) begin
              state <= ST_OUT;
            end else begin
              j     <= j + 4'd1;
              t     <= '0;
              state <= ST_FA;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (j == 4'd15) begin
              state <= ST_LOAD;
            end else begin
              j     <= j + 4'd1;
              t     <= '0;
              state <= ST_FA;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire
